// ===== sv/lens_undistort_coordinate_map_defines.svh =====
// assertion macros for the coordinate map
`ifndef LENS_UNDISTORT_COORDINATE_MAP_DEFINES_SVH
`define LENS_UNDISTORT_COORDINATE_MAP_DEFINES_SVH

`ifndef SYNTH
`define LUCM_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("implication check failed");
`define LUCM_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("next cycle check failed");
`else
`define LUCM_ASSERT_IMP(label, clk, rst_n, a, c)
`define LUCM_ASSERT_NXT(label, clk, rst_n, a, c)
`endif

`endif

// ===== sv/lucm_pkg.sv =====
`default_nettype none

package lucm_pkg;

    typedef struct packed {
        logic [9:0] out_col;
        logic [9:0] out_row;
    } t_in;

    typedef struct packed {
        logic [9:0] src_col;
        logic [9:0] src_row;
        logic       inside_res;
    } t_res;

    typedef enum logic [2:0] {
        CFG_FOCAL_X,
        CFG_FOCAL_Y,
        CFG_CENTER_X,
        CFG_CENTER_Y,
        CFG_RADIAL_K1,
        CFG_RADIAL_K2,
        CFG_TANGENTIAL_P1,
        CFG_TANGENTIAL_P2
    } t_cfg_idx;

    typedef struct packed {
        logic [18:0] rem;
        logic [27:0] q;
    } t_div;

    localparam int DIV_STAGES = 28;

    localparam logic signed [33:0] Q_ONE = 34'sd16777216;
    localparam logic signed [33:0] Q_MAX = 34'sd134217727;
    localparam logic signed [33:0] Q_MIN = -34'sd134217728;

    function automatic logic signed [27:0] sat28(input logic signed [33:0] v);
        logic signed [27:0] r;
        if (v > Q_MAX) begin
            r = 28'sh7ffffff;
        end else if (v < Q_MIN) begin
            r = 28'sh8000000;
        end else begin
            r = v[27:0];
        end
        return r;
    endfunction

    // q4.24 product back to q4.24, toward zero, saturated
    function automatic logic signed [27:0] qfix(input logic signed [55:0] p);
        logic signed [56:0] b;
        b = 57'(p) + (p[55] ? 57'sd16777215 : 57'sd0);
        return sat28(34'($signed(b[56:24])));
    endfunction

    // one restoring division step
    function automatic t_div div_step(input logic [18:0] rem, input logic b,
                                      input logic [18:0] d, input logic [27:0] q);
        t_div       r;
        logic [19:0] sh;
        sh = {rem, b};
        if (sh >= {1'b0, d}) begin
            r.rem = 19'(sh - {1'b0, d});
            r.q   = {q[26:0], 1'b1};
        end else begin
            r.rem = sh[18:0];
            r.q   = {q[26:0], 1'b0};
        end
        return r;
    endfunction

    // pixel position from the projection sum, toward zero
    function automatic logic signed [17:0] pix_trunc(input logic signed [48:0] s);
        logic signed [49:0] t;
        t = 50'(s) + (s[48] ? 50'sd4294967295 : 50'sd0);
        return t[49:32];
    endfunction

endpackage

`default_nettype wire

// ===== sv/lens_undistort_coordinate_map.sv =====
// lens undistortion coordinate map, radial and tangential model
//
// input: start with i_in (out_col, out_row); a transfer happens at each
// rising edge with start high and busy low. busy is always low, so one
// coordinate can enter on every clock.
// output: o_res (src_col, src_row, inside_res) with o_res_strobe for one
// cycle, once the coordinate has passed the whole pipeline. the result transfer is
// the edge that ends the strobe cycle; the receiver cannot hold it off.
// throughput is one coordinate per clock; the pipeline is the input
// register, a 28 stage one bit per stage divider for the normalization and
// 12 arithmetic stages after it.
// configuration: i_cfg_valid, i_cfg_index, i_cfg_data, o_cfg_ready always
// high; write only while no coordinate is in flight.
// reset (synchronous, active low) empties the pipeline and loads the
// default lens registers; nothing is lost or repeated since the pipeline
// never stalls.
`default_nettype none

module lens_undistort_coordinate_map #(
    parameter int IMAGE_WIDTH  = 1024,
    parameter int IMAGE_HEIGHT = 1024
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    input  wire lucm_pkg::t_in  i_in,
    output logic                busy,
    output logic                o_res_strobe,
    output lucm_pkg::t_res      o_res,
    input  wire logic           i_cfg_valid,
    input  wire logic [2:0]     i_cfg_index,
    input  wire logic [27:0]    i_cfg_data,
    output logic                o_cfg_ready
);

    localparam int NV = lucm_pkg::DIV_STAGES + 13;
    localparam logic [16:0] W_LIM = 17'(IMAGE_WIDTH);
    localparam logic [16:0] H_LIM = 17'(IMAGE_HEIGHT);

    logic [18:0]        r_focal_x, r_focal_y;
    logic [17:0]        r_center_x, r_center_y;
    logic signed [27:0] r_k1, r_k2, r_p1, r_p2;

    logic [NV-1:0] r_v;

    logic [18:0] dx, dy;
    logic        acc;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign acc         = start && !busy;
    assign dx          = (r_focal_x == 19'd0) ? 19'd1 : r_focal_x;
    assign dy          = (r_focal_y == 19'd0) ? 19'd1 : r_focal_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal_x  <= 19'd117415;
            r_focal_y  <= 19'd117068;
            r_center_x <= 18'd94007;
            r_center_y <= 18'd63584;
            r_k1       <= -28'sd4754799;
            r_k2       <= 28'sd1240827;
            r_p1       <= 28'sd3248;
            r_p2       <= 28'sd296;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (lucm_pkg::t_cfg_idx'(i_cfg_index))
                lucm_pkg::CFG_FOCAL_X:       r_focal_x  <= i_cfg_data[18:0];
                lucm_pkg::CFG_FOCAL_Y:       r_focal_y  <= i_cfg_data[18:0];
                lucm_pkg::CFG_CENTER_X:      r_center_x <= i_cfg_data[17:0];
                lucm_pkg::CFG_CENTER_Y:      r_center_y <= i_cfg_data[17:0];
                lucm_pkg::CFG_RADIAL_K1:     r_k1       <= i_cfg_data;
                lucm_pkg::CFG_RADIAL_K2:     r_k2       <= i_cfg_data;
                lucm_pkg::CFG_TANGENTIAL_P1: r_p1       <= i_cfg_data;
                lucm_pkg::CFG_TANGENTIAL_P2: r_p2       <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[NV-2:0], acc};
        end
    end

    // normalization numerators
    logic signed [18:0] num_x, num_y;
    logic [17:0]        m_x, m_y;

    assign num_x = $signed({1'b0, i_in.out_col, 8'b0}) - $signed({1'b0, r_center_x});
    assign num_y = $signed({1'b0, i_in.out_row, 8'b0}) - $signed({1'b0, r_center_y});
    assign m_x   = num_x[18] ? 18'(-num_x) : num_x[17:0];
    assign m_y   = num_y[18] ? 18'(-num_y) : num_y[17:0];

    // divider pipeline
    logic [18:0] r_xrem [0:lucm_pkg::DIV_STAGES];
    logic [18:0] r_yrem [0:lucm_pkg::DIV_STAGES];
    logic [27:0] r_xq   [0:lucm_pkg::DIV_STAGES];
    logic [27:0] r_yq   [0:lucm_pkg::DIV_STAGES];
    logic        r_xneg [0:lucm_pkg::DIV_STAGES];
    logic        r_yneg [0:lucm_pkg::DIV_STAGES];
    logic        r_xovf [0:lucm_pkg::DIV_STAGES];
    logic        r_yovf [0:lucm_pkg::DIV_STAGES];
    logic [3:0]  r_xlo  [0:3];
    logic [3:0]  r_ylo  [0:3];

    always_ff @(posedge i_clk) begin
        r_xrem[0] <= {5'b0, m_x[17:4]};
        r_yrem[0] <= {5'b0, m_y[17:4]};
        r_xq[0]   <= '0;
        r_yq[0]   <= '0;
        r_xneg[0] <= num_x[18];
        r_yneg[0] <= num_y[18];
        r_xovf[0] <= {5'b0, m_x} >= {dx, 4'b0};
        r_yovf[0] <= {5'b0, m_y} >= {dy, 4'b0};
        r_xlo[0]  <= m_x[3:0];
        r_ylo[0]  <= m_y[3:0];
    end

    for (genvar s = 1; s <= lucm_pkg::DIV_STAGES; s++) begin : g_div
        logic    bx, by;
        lucm_pkg::t_div nx, ny;
        if (s <= 4) begin : g_hi
            assign bx = r_xlo[s-1][4-s];
            assign by = r_ylo[s-1][4-s];
        end else begin : g_lo
            assign bx = 1'b0;
            assign by = 1'b0;
        end
        if (s < 4) begin : g_lo_carry
            always_ff @(posedge i_clk) begin
                r_xlo[s] <= r_xlo[s-1];
                r_ylo[s] <= r_ylo[s-1];
            end
        end
        assign nx = lucm_pkg::div_step(r_xrem[s-1], bx, dx, r_xq[s-1]);
        assign ny = lucm_pkg::div_step(r_yrem[s-1], by, dy, r_yq[s-1]);
        always_ff @(posedge i_clk) begin
            r_xrem[s] <= nx.rem;
            r_yrem[s] <= ny.rem;
            r_xq[s]   <= nx.q;
            r_yq[s]   <= ny.q;
            r_xneg[s] <= r_xneg[s-1];
            r_yneg[s] <= r_yneg[s-1];
            r_xovf[s] <= r_xovf[s-1];
            r_yovf[s] <= r_yovf[s-1];
        end
    end

    localparam int DS = lucm_pkg::DIV_STAGES;

    logic signed [27:0] r_ax, r_ay;
    logic signed [55:0] r_bpx2, r_bpy2, r_bpxy;
    logic signed [27:0] r_bx, r_by;
    logic signed [27:0] r_cx2, r_cy2, r_cxy, r_cr2, r_cx, r_cy;
    logic signed [55:0] r_dpr4, r_dpk1;
    logic signed [27:0] r_dtx, r_dty, r_dxy, r_dx, r_dy;
    logic signed [27:0] r_er4, r_ek1r2, r_etx, r_ety, r_exy, r_ex, r_ey;
    logic signed [55:0] r_fpk2, r_fpt1xy, r_fpt2tx, r_fpt1ty, r_fpt2xy;
    logic signed [27:0] r_fk1r2, r_fx, r_fy;
    logic signed [27:0] r_grad, r_ga, r_gb, r_gc, r_gd, r_gx, r_gy;
    logic signed [55:0] r_hpx, r_hpy;
    logic signed [27:0] r_ha, r_hb, r_hc, r_hd;
    logic signed [27:0] r_ixc, r_iyc;
    logic signed [47:0] r_jpc, r_jpr;
    logic signed [48:0] r_ksc, r_ksr;
    lucm_pkg::t_res     r_res;

    logic signed [17:0] col, row;
    logic               in_img;

    always_ff @(posedge i_clk) begin
        if (r_xovf[DS] || r_xq[DS][27]) begin
            r_ax <= r_xneg[DS] ? 28'sh8000000 : 28'sh7ffffff;
        end else begin
            r_ax <= r_xneg[DS] ? -$signed(r_xq[DS]) : $signed(r_xq[DS]);
        end
        if (r_yovf[DS] || r_yq[DS][27]) begin
            r_ay <= r_yneg[DS] ? 28'sh8000000 : 28'sh7ffffff;
        end else begin
            r_ay <= r_yneg[DS] ? -$signed(r_yq[DS]) : $signed(r_yq[DS]);
        end

        r_bpx2 <= r_ax * r_ax;
        r_bpy2 <= r_ay * r_ay;
        r_bpxy <= r_ax * r_ay;
        r_bx   <= r_ax;
        r_by   <= r_ay;

        r_cx2 <= lucm_pkg::qfix(r_bpx2);
        r_cy2 <= lucm_pkg::qfix(r_bpy2);
        r_cxy <= lucm_pkg::qfix(r_bpxy);
        r_cr2 <= lucm_pkg::sat28(34'(lucm_pkg::qfix(r_bpx2)) + 34'(lucm_pkg::qfix(r_bpy2)));
        r_cx  <= r_bx;
        r_cy  <= r_by;

        r_dpr4 <= r_cr2 * r_cr2;
        r_dpk1 <= r_k1 * r_cr2;
        r_dtx  <= lucm_pkg::sat28(34'(r_cr2) + 34'(r_cx2) + 34'(r_cx2));
        r_dty  <= lucm_pkg::sat28(34'(r_cr2) + 34'(r_cy2) + 34'(r_cy2));
        r_dxy  <= r_cxy;
        r_dx   <= r_cx;
        r_dy   <= r_cy;

        r_er4   <= lucm_pkg::qfix(r_dpr4);
        r_ek1r2 <= lucm_pkg::qfix(r_dpk1);
        r_etx   <= r_dtx;
        r_ety   <= r_dty;
        r_exy   <= r_dxy;
        r_ex    <= r_dx;
        r_ey    <= r_dy;

        r_fpk2   <= r_k2 * r_er4;
        r_fpt1xy <= r_p1 * r_exy;
        r_fpt2tx <= r_p2 * r_etx;
        r_fpt1ty <= r_p1 * r_ety;
        r_fpt2xy <= r_p2 * r_exy;
        r_fk1r2  <= r_ek1r2;
        r_fx     <= r_ex;
        r_fy     <= r_ey;

        r_grad <= lucm_pkg::sat28(lucm_pkg::Q_ONE + 34'(r_fk1r2)
                                  + 34'(lucm_pkg::qfix(r_fpk2)));
        r_ga   <= lucm_pkg::qfix(r_fpt1xy);
        r_gb   <= lucm_pkg::qfix(r_fpt2tx);
        r_gc   <= lucm_pkg::qfix(r_fpt1ty);
        r_gd   <= lucm_pkg::qfix(r_fpt2xy);
        r_gx   <= r_fx;
        r_gy   <= r_fy;

        r_hpx <= r_gx * r_grad;
        r_hpy <= r_gy * r_grad;
        r_ha  <= r_ga;
        r_hb  <= r_gb;
        r_hc  <= r_gc;
        r_hd  <= r_gd;

        r_ixc <= lucm_pkg::sat28(34'(lucm_pkg::qfix(r_hpx)) + 34'(r_ha) + 34'(r_ha)
                                 + 34'(r_hb));
        r_iyc <= lucm_pkg::sat28(34'(lucm_pkg::qfix(r_hpy)) + 34'(r_hc) + 34'(r_hd)
                                 + 34'(r_hd));

        r_jpc <= $signed({1'b0, r_focal_x}) * r_ixc;
        r_jpr <= $signed({1'b0, r_focal_y}) * r_iyc;

        r_ksc <= 49'(r_jpc) + $signed({7'b0, r_center_x, 24'b0});
        r_ksr <= 49'(r_jpr) + $signed({7'b0, r_center_y, 24'b0});

        r_res.inside_res <= in_img;
        r_res.src_col    <= in_img ? col[9:0] : 10'd0;
        r_res.src_row    <= in_img ? row[9:0] : 10'd0;
    end

    assign col    = lucm_pkg::pix_trunc(r_ksc);
    assign row    = lucm_pkg::pix_trunc(r_ksr);
    assign in_img = !col[17] && !row[17] && (col[16:0] < W_LIM) && (row[16:0] < H_LIM);

    assign o_res_strobe = r_v[NV-1];
    assign o_res        = r_res;

`include "lens_undistort_coordinate_map_defines.svh"

    `LUCM_ASSERT_IMP(a_outside_zero, i_clk, i_rst_n, o_res_strobe && !o_res.inside_res,
        o_res.src_col == 10'd0 && o_res.src_row == 10'd0)
    `LUCM_ASSERT_NXT(a_entry_valid, i_clk, i_rst_n, start && !busy, r_v[0])

endmodule

`default_nettype wire

// ===== tb/sv/lens_undistort_coordinate_map_chk.sv =====
`default_nettype none

module lens_undistort_coordinate_map_chk (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic           i_busy,
    input  wire lucm_pkg::t_in  i_in,
    input  wire logic           i_res_strobe,
    input  wire lucm_pkg::t_res i_res,
    input  wire logic           i_cfg_valid,
    input  wire logic           i_cfg_ready,
    input  wire logic [2:0]     i_cfg_index,
    input  wire logic [27:0]    i_cfg_data,
    output int                  o_errors,
    output int                  o_pending,
    output int                  o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint QONE = 64'sd16777216;
    localparam longint QHI  = 64'sd134217727;
    localparam longint QLO  = -64'sd134217728;

    longint fx, fy, cx, cy, k1, k2, p1, p2;
    lucm_pkg::t_res expected_q[$];

    function automatic longint clip(input longint v);
        if (v > QHI) return QHI;
        if (v < QLO) return QLO;
        return v;
    endfunction

    function automatic longint fmul(input longint a, input longint b);
        longint p;
        longint m;
        p = a * b;
        m = (p < 0 ? -p : p) >>> 24;
        return clip(p < 0 ? -m : m);
    endfunction

    function automatic longint norm(input longint pix, input longint c, input longint f);
        longint num;
        longint m;
        longint q;
        num = (pix <<< 8) - c;
        m = num < 0 ? -num : num;
        q = (m <<< 24) / (f == 0 ? 64'sd1 : f);
        if (q > (64'sd1 <<< 28)) q = 64'sd1 <<< 28;
        return clip(num < 0 ? -q : q);
    endfunction

    function automatic longint proj(input longint corr, input longint f, input longint c);
        longint s;
        longint m;
        s = f * corr + (c <<< 24);
        m = (s < 0 ? -s : s) >>> 32;
        return s < 0 ? -m : m;
    endfunction

    function automatic lucm_pkg::t_res remap(input lucm_pkg::t_in it);
        longint x, y, x2, y2, xy, r2, r4, rad, tx, ty, xc, yc, col, row;
        lucm_pkg::t_res r;
        x = norm(longint'(it.out_col), cx, fx);
        y = norm(longint'(it.out_row), cy, fy);
        x2 = fmul(x, x);
        y2 = fmul(y, y);
        xy = fmul(x, y);
        r2 = clip(x2 + y2);
        r4 = fmul(r2, r2);
        rad = clip(QONE + fmul(k1, r2) + fmul(k2, r4));
        tx = clip(r2 + 2 * x2);
        ty = clip(r2 + 2 * y2);
        xc = clip(fmul(x, rad) + 2 * fmul(p1, xy) + fmul(p2, tx));
        yc = clip(fmul(y, rad) + fmul(p1, ty) + 2 * fmul(p2, xy));
        col = proj(xc, fx, cx);
        row = proj(yc, fy, cy);
        r = '0;
        if (col >= 0 && row >= 0 && col < 1024 && row < 1024) begin
            r.src_col = col[9:0];
            r.src_row = row[9:0];
            r.inside_res = 1'b1;
        end
        return r;
    endfunction

    assign o_pending = expected_q.size();

    always @(posedge i_clk) begin
        lucm_pkg::t_res e;
        if (!i_rst_n) begin
            fx <= 117415;
            fy <= 117068;
            cx <= 94007;
            cy <= 63584;
            k1 <= -4754799;
            k2 <= 1240827;
            p1 <= 3248;
            p2 <= 296;
            expected_q.delete();
            o_errors <= 0;
            o_results <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (lucm_pkg::t_cfg_idx'(i_cfg_index))
                    lucm_pkg::CFG_FOCAL_X: fx <= longint'(i_cfg_data[18:0]);
                    lucm_pkg::CFG_FOCAL_Y: fy <= longint'(i_cfg_data[18:0]);
                    lucm_pkg::CFG_CENTER_X: cx <= longint'(i_cfg_data[17:0]);
                    lucm_pkg::CFG_CENTER_Y: cy <= longint'(i_cfg_data[17:0]);
                    lucm_pkg::CFG_RADIAL_K1: k1 <= longint'($signed(i_cfg_data));
                    lucm_pkg::CFG_RADIAL_K2: k2 <= longint'($signed(i_cfg_data));
                    lucm_pkg::CFG_TANGENTIAL_P1: p1 <= longint'($signed(i_cfg_data));
                    lucm_pkg::CFG_TANGENTIAL_P2: p2 <= longint'($signed(i_cfg_data));
                    default: ;
                endcase
            end
            if (i_res_strobe) begin
                o_results <= o_results + 1;
                if (expected_q.size() == 0) begin
                    $error("result with no pending coordinate");
                    o_errors <= o_errors + 1;
                end else begin
                    e = expected_q.pop_front();
                    if (e !== i_res) begin
                        o_errors <= o_errors + 1;
                        if (e.src_col !== i_res.src_col)
                            $error("src_col expected %0d actual %0d", e.src_col, i_res.src_col);
                        if (e.src_row !== i_res.src_row)
                            $error("src_row expected %0d actual %0d", e.src_row, i_res.src_row);
                        if (e.inside_res !== i_res.inside_res)
                            $error("inside_res expected %0d actual %0d",
                                   e.inside_res, i_res.inside_res);
                    end
                end
            end
            if (i_start && !i_busy) expected_q.push_back(remap(i_in));
        end
    end
endmodule

`default_nettype wire

// ===== tb/sv/lens_undistort_coordinate_map_tb.sv =====
`default_nettype none

module lens_undistort_coordinate_map_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           start = 1'b0;
    lucm_pkg::t_in  coord = '0;
    logic           busy;
    logic           res_strobe;
    lucm_pkg::t_res res;
    logic           cfg_valid = 1'b0;
    logic [2:0]     cfg_index = '0;
    logic [27:0]    cfg_data = '0;
    logic           cfg_ready;
    int             errors, pending, results;
    int             idle_pct = 0;
    int             sent = 0;
    int             quiet = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    lens_undistort_coordinate_map i_dut (
        .i_clk(clk), .i_rst_n(rst_n), .start(start), .i_in(coord), .busy(busy),
        .o_res_strobe(res_strobe), .o_res(res), .i_cfg_valid(cfg_valid),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data), .o_cfg_ready(cfg_ready)
    );

    lens_undistort_coordinate_map_chk i_chk (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .i_busy(busy), .i_in(coord),
        .i_res_strobe(res_strobe), .i_res(res), .i_cfg_valid(cfg_valid),
        .i_cfg_ready(cfg_ready), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    always @(posedge clk) begin
        if ((start && !busy) || (cfg_valid && cfg_ready) || res_strobe) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
        if (quiet > STALL_LIMIT) begin
            $display("watchdog expired");
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic write_reg(input lucm_pkg::t_cfg_idx idx, input logic [27:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic send(input logic [9:0] c, input logic [9:0] r);
        while ($urandom_range(99, 0) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        coord <= '{out_col: c, out_row: r};
        do @(posedge clk); while (busy);
        sent++;
    endtask

    task automatic drain();
        while (pending != 0) @(posedge clk);
        repeat (45) @(posedge clk);
    endtask

    task automatic lens_setup(input int kind);
        logic [18:0] f;
        case (kind)
            0: begin
                write_reg(lucm_pkg::CFG_FOCAL_X, 28'd117415);
                write_reg(lucm_pkg::CFG_FOCAL_Y, 28'd117068);
                write_reg(lucm_pkg::CFG_CENTER_X, 28'd94007);
                write_reg(lucm_pkg::CFG_CENTER_Y, 28'd63584);
                write_reg(lucm_pkg::CFG_RADIAL_K1, -28'sd4754799);
                write_reg(lucm_pkg::CFG_RADIAL_K2, 28'd1240827);
                write_reg(lucm_pkg::CFG_TANGENTIAL_P1, 28'd3248);
                write_reg(lucm_pkg::CFG_TANGENTIAL_P2, 28'd296);
            end
            1: begin
                write_reg(lucm_pkg::CFG_FOCAL_X, 28'd0);
                write_reg(lucm_pkg::CFG_FOCAL_Y, 28'd256);
                write_reg(lucm_pkg::CFG_CENTER_X, 28'd0);
                write_reg(lucm_pkg::CFG_CENTER_Y, 28'h3ffff);
                write_reg(lucm_pkg::CFG_RADIAL_K1, 28'h8000000);
                write_reg(lucm_pkg::CFG_RADIAL_K2, 28'h7ffffff);
                write_reg(lucm_pkg::CFG_TANGENTIAL_P1, 28'h7ffffff);
                write_reg(lucm_pkg::CFG_TANGENTIAL_P2, 28'h8000000);
            end
            2: begin
                write_reg(lucm_pkg::CFG_FOCAL_X, 28'h7ffff);
                write_reg(lucm_pkg::CFG_FOCAL_Y, 28'h7ffff);
                write_reg(lucm_pkg::CFG_CENTER_X, 28'h3ffff);
                write_reg(lucm_pkg::CFG_CENTER_Y, 28'd0);
                write_reg(lucm_pkg::CFG_RADIAL_K1, 28'd0);
                write_reg(lucm_pkg::CFG_RADIAL_K2, 28'd0);
                write_reg(lucm_pkg::CFG_TANGENTIAL_P1, 28'd0);
                write_reg(lucm_pkg::CFG_TANGENTIAL_P2, 28'd0);
            end
            default: begin
                f = 19'($urandom_range(300000, 60000));
                write_reg(lucm_pkg::CFG_FOCAL_X, 28'(f));
                write_reg(lucm_pkg::CFG_FOCAL_Y, 28'($urandom_range(300000, 60000)));
                write_reg(lucm_pkg::CFG_CENTER_X, 28'($urandom_range(262143, 0)));
                write_reg(lucm_pkg::CFG_CENTER_Y, 28'($urandom_range(262143, 0)));
                write_reg(lucm_pkg::CFG_RADIAL_K1, 28'($urandom));
                write_reg(lucm_pkg::CFG_RADIAL_K2, 28'($urandom));
                write_reg(lucm_pkg::CFG_TANGENTIAL_P1, 28'($urandom));
                write_reg(lucm_pkg::CFG_TANGENTIAL_P2, 28'($urandom));
            end
        endcase
    endtask

    initial begin
        int pct[4] = '{0, 83, 0, 36};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // reset lens, corners and center
        send(10'd0, 10'd0);
        send(10'd1023, 10'd1023);
        send(10'd0, 10'd1023);
        send(10'd1023, 10'd0);
        send(10'd367, 10'd248);
        send(10'd368, 10'd249);
        send(10'h2aa, 10'h155);
        send(10'h155, 10'h2aa);
        start <= 1'b0;
        drain();
        for (int k = 1; k < 3; k++) begin
            lens_setup(k);
            send(10'd0, 10'd0);
            send(10'd1023, 10'd1023);
            send(10'd1, 10'd1022);
            send(10'd512, 10'd512);
            start <= 1'b0;
            drain();
        end
        for (int ph = 0; ph < 8; ph++) begin
            lens_setup(ph % 4 == 3 ? 3 : (ph < 4 ? 0 : ph % 3));
            idle_pct = pct[ph % 4];
            for (int n = 0; n < 48; n++) begin
                if ($urandom_range(3, 0) == 0)
                    send(10'($urandom), 10'($urandom));
                else
                    send(10'($urandom_range(800, 0)), 10'($urandom_range(560, 0)));
            end
            start <= 1'b0;
            drain();
        end
        $display("coordinates sent %0d, results checked %0d", sent, results);
        $display("over default, extreme and random lenses");
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

`default_nettype wire
